// ===== hdl/dspe_pkg.sv =====
package dspe_pkg;

	localparam int VTX_W      = 4;
	localparam int DIST_W     = 10;
	localparam int WEIGHT_W   = 16;
	localparam int VCOUNT_W   = 5;
	localparam int SRC_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int VTX_LIMIT  = 16;

	localparam logic [DIST_W-1:0] NO_PATH = 10'd999;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_RUN   = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_VERTEX = 2'd1;

	typedef struct packed {
		logic clr_step;
		logic edge_wr;
		logic start_run;
		logic j_clr;
		logic sel_step;
		logic mark;
		logic relax_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic scan_last;
		logic found;
		logic iter_end;
		logic n_zero;
		logic out_free;
	} sts_t;

endpackage

// ===== hdl/dspe_ctrl.sv =====
module dspe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_kind,
	output logic              in_stall,
	input  dspe_pkg::sts_t    sts,
	output dspe_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_SEL,
		S_MARK,
		S_RELAX,
		S_DRAIN,
		S_EMIT
	} state_t;

	state_t state_q;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_CLEAR: cmd.clr_step = 1'b1;
			S_IDLE: begin
				cmd.edge_wr   = in_valid && (in_kind == dspe_pkg::KIND_WRITE);
				cmd.start_run = in_valid && (in_kind == dspe_pkg::KIND_RUN);
			end
			S_CHECK: cmd.j_clr = 1'b1;
			S_SEL:   cmd.sel_step = 1'b1;
			S_MARK: begin
				cmd.j_clr = 1'b1;
				cmd.mark  = sts.found;
			end
			S_RELAX: cmd.relax_step = 1'b1;
			S_DRAIN: cmd.j_clr = 1'b1;
			S_EMIT:  cmd.emit = sts.out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			unique case (state_q)
				S_CLEAR: if (sts.clr_last) state_q <= S_IDLE;
				S_IDLE:  if (cmd.start_run) state_q <= S_CHECK;
				S_CHECK: begin
					if (sts.n_zero) state_q <= S_IDLE;
					else if (sts.iter_end) state_q <= S_EMIT;
					else state_q <= S_SEL;
				end
				S_SEL:   if (sts.scan_last) state_q <= S_MARK;
				S_MARK:  state_q <= sts.found ? S_RELAX : S_EMIT;
				S_RELAX: if (sts.scan_last) state_q <= S_DRAIN;
				S_DRAIN: state_q <= sts.iter_end ? S_EMIT : S_SEL;
				S_EMIT:  if (cmd.emit && sts.scan_last) state_q <= S_IDLE;
				default: state_q <= S_CLEAR;
			endcase
		end
	end

endmodule

// ===== hdl/dspe_dpath.sv =====
module dspe_dpath #(
	parameter int MAX_VERTICES = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dspe_pkg::cmd_t                      cmd,
	output dspe_pkg::sts_t                      sts,
	input  logic                                cfg_wr,
	input  logic [dspe_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dspe_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [dspe_pkg::VTX_W-1:0]          row,
	input  logic [dspe_pkg::VTX_W-1:0]          col,
	input  logic [dspe_pkg::WEIGHT_W-1:0]       weight,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic [dspe_pkg::VTX_W-1:0]          vertex,
	output logic [dspe_pkg::DIST_W-1:0]         distance,
	output logic                                last
);

	localparam int VN    = (MAX_VERTICES < dspe_pkg::VTX_LIMIT) ? MAX_VERTICES
	                       : dspe_pkg::VTX_LIMIT;
	localparam int VB    = $clog2(VN);
	localparam int JW    = $clog2(VN + 1);
	localparam int AW    = 2 * VB;
	localparam int DEPTH = VN << VB;

	logic [dspe_pkg::WEIGHT_W-1:0] edge_mem [DEPTH];
	logic [dspe_pkg::WEIGHT_W-1:0] w_s1;
	logic                          v_s1;
	logic [VB-1:0]                 j_s1;

	logic [AW-1:0]                   clr_q;
	logic [dspe_pkg::VCOUNT_W-1:0]   vcount_q;
	logic [dspe_pkg::SRC_W-1:0]      source_q;
	logic [JW-1:0]                   n_q;
	logic [JW-1:0]                   j_q;
	logic [JW-1:0]                   iter_q;
	logic                            found_q;
	logic [dspe_pkg::DIST_W-1:0]     best_q;
	logic [VB-1:0]                   pick_q;
	logic [VB-1:0]                   u_q;
	logic [dspe_pkg::DIST_W-1:0]     du_q;
	logic [dspe_pkg::DIST_W-1:0]     dist_q [VN];
	logic                            done_q [VN];

	logic                            ov_q;
	logic [dspe_pkg::VTX_W-1:0]      vertex_q;
	logic [dspe_pkg::DIST_W-1:0]     distance_q;
	logic                            last_q;

	logic [JW-1:0]                   n_next;
	logic                            src_in;
	logic                            wr_ok;
	logic [AW-1:0]                   wr_addr;
	logic [AW-1:0]                   rd_addr;
	logic [VB-1:0]                   j_idx;
	logic                            sel_hit;
	logic [dspe_pkg::WEIGHT_W:0]     cand;
	logic                            relax_hit;

	assign j_idx   = j_q[VB-1:0];
	assign n_next  = (vcount_q > dspe_pkg::VCOUNT_W'(VN)) ? JW'(VN) : JW'(vcount_q);
	// A source outside the vertices in use leaves every vertex unreachable.
	assign src_in  = (5'(n_next) > {1'b0, source_q});
	assign wr_ok   = ({1'b0, row} < 5'(VN)) && ({1'b0, col} < 5'(VN));
	assign wr_addr = {row[VB-1:0], col[VB-1:0]};
	assign rd_addr = {u_q, j_idx};
	assign sel_hit = !done_q[j_idx] && (dist_q[j_idx] < best_q);

	assign cand      = (dspe_pkg::WEIGHT_W+1)'(du_q) + (dspe_pkg::WEIGHT_W+1)'(w_s1);
	assign relax_hit = v_s1 && !done_q[j_s1] && (w_s1 != '0)
	                   && (cand < (dspe_pkg::WEIGHT_W+1)'(dist_q[j_s1]));

	assign sts.clr_last  = (clr_q == AW'(DEPTH - 1));
	assign sts.scan_last = (j_q == n_q - JW'(1));
	assign sts.found     = found_q;
	assign sts.iter_end  = ((iter_q + JW'(1)) >= n_q);
	assign sts.n_zero    = (n_q == '0);
	assign sts.out_free  = !ov_q || !out_stall;

	assign out_valid = ov_q;
	assign vertex    = vertex_q;
	assign distance  = distance_q;
	assign last      = last_q;

	// One write port shared by the reset sweep and host writes; one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			edge_mem[clr_q] <= '0;
		end else if (cmd.edge_wr && wr_ok) begin
			edge_mem[wr_addr] <= weight;
		end
		w_s1 <= edge_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			vcount_q <= dspe_pkg::VCOUNT_W'(16);
			source_q <= '0;
			n_q      <= '0;
			j_q      <= '0;
			iter_q   <= '0;
			found_q  <= 1'b0;
			v_s1     <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + AW'(1);
			if (cfg_wr && cfg_index == dspe_pkg::REG_VERTEX_COUNT) begin
				vcount_q <= cfg_data;
			end
			if (cfg_wr && cfg_index == dspe_pkg::REG_SOURCE_VERTEX) begin
				source_q <= cfg_data[dspe_pkg::SRC_W-1:0];
			end
			if (cmd.start_run) n_q <= n_next;
			if (cmd.start_run) iter_q <= '0;
			else if (cmd.mark) iter_q <= iter_q + JW'(1);
			if (cmd.j_clr) begin
				j_q     <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.sel_step || cmd.relax_step || cmd.emit) j_q <= j_q + JW'(1);
				if (cmd.sel_step && sel_hit) found_q <= 1'b1;
			end
			v_s1 <= cmd.relax_step;
			if (cmd.emit) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		j_s1 <= j_idx;
		if (cmd.j_clr) begin
			best_q <= dspe_pkg::NO_PATH;
		end else if (cmd.sel_step && sel_hit) begin
			best_q <= dist_q[j_idx];
			pick_q <= j_idx;
		end
		if (cmd.mark) begin
			u_q  <= pick_q;
			du_q <= best_q;
		end
		if (cmd.start_run) begin
			for (int k = 0; k < VN; k++) begin
				dist_q[k] <= (src_in && (source_q == dspe_pkg::SRC_W'(k))) ? '0
				             : dspe_pkg::NO_PATH;
				done_q[k] <= 1'b0;
			end
		end else begin
			if (relax_hit) dist_q[j_s1] <= cand[dspe_pkg::DIST_W-1:0];
			if (cmd.mark) done_q[pick_q] <= 1'b1;
		end
		if (cmd.emit) begin
			vertex_q   <= dspe_pkg::VTX_W'(j_q);
			distance_q <= dist_q[j_idx];
			last_q     <= sts.scan_last;
		end
	end

endmodule

// ===== hdl/dense_shortest_path_engine_unit.sv =====
// Single-source shortest paths over a dense edge-weight matrix. After reset the
// block sweeps the edge store to zero, one entry a cycle (MAX_VERTICES limited to 16,
// times the next power of two of that figure: 256 entries by default), and holds in_stall
// high meanwhile. An edge write (kind 0) leaves in_stall low, so writes may follow
// back to back. A run (kind 1) with n vertices in use keeps in_stall high until the
// last of its beats is loaded: one shared compare unit scans the distance registers
// to pick the nearest vertex and then walks that vertex's matrix row through the
// single read port of the edge store, and at the end the n result beats are loaded,
// one per cycle while out_stall does not hold a loaded beat. A search with nothing
// reachable left ends early. Configuration is written through cfg_index and cfg_data
// and is taken in every cycle.
module dense_shortest_path_engine_unit #(
	parameter int MAX_VERTICES = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dspe_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dspe_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                kind,
	input  logic [dspe_pkg::VTX_W-1:0]          row,
	input  logic [dspe_pkg::VTX_W-1:0]          col,
	input  logic [dspe_pkg::WEIGHT_W-1:0]       weight,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [dspe_pkg::VTX_W-1:0]          vertex,
	output logic [dspe_pkg::DIST_W-1:0]         distance,
	output logic                                last
);

	dspe_pkg::cmd_t cmd;
	dspe_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	dspe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_kind  (kind),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	dspe_dpath #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.row       (row),
		.col       (col),
		.weight    (weight),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.vertex    (vertex),
		.distance  (distance),
		.last      (last)
	);

	// Within a run the next beat is loaded in the same cycle the previous one is taken.
	a_emit_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid && vertex == $past(vertex) + 4'd1)
		else $error("result beats of a run are not contiguous");

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> distance <= dspe_pkg::NO_PATH)
		else $error("distance beyond the unreachable mark");

	a_run_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && kind == dspe_pkg::KIND_RUN |=> in_stall)
		else $error("input taken during a search");

endmodule
